/* rtl/pixel_color_filter_chain_defines.svh */
// Assertion macros shared by the colour filter chain RTL
`ifndef PIXEL_COLOR_FILTER_CHAIN_DEFINES_SVH
`define PIXEL_COLOR_FILTER_CHAIN_DEFINES_SVH

// Antecedent and consequent in the same cycle
`define PCFC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pcfc: same-cycle check failed");

// Consequent in the cycle after the antecedent
`define PCFC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pcfc: next-cycle check failed");

`endif

/* rtl/pcfc_pkg.sv */
// Package: types and constants of the colour filter chain
`default_nettype none

package pcfc_pkg;

	// Number of filter stages in the chain and number of register pairs
	localparam int NUM_STAGES   = 4;
	localparam int REG_STAGES   = 4;
	localparam int NUM_CFG_REGS = 2 * REG_STAGES;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_STAGE_W  = (REG_STAGES > 1) ? $clog2(REG_STAGES) : 1;

	// Register cycles per filter stage and through the whole chain
	localparam int STAGE_DEPTH = 3;
	localparam int LATENCY     = STAGE_DEPTH * NUM_STAGES;

	// Low bit of a register index: op or value of a stage
	localparam logic CFG_SEL_OP    = 1'b0;
	localparam logic CFG_SEL_VALUE = 1'b1;

	// 1.0 in Q4.12
	localparam logic [15:0] ONE_Q12 = 16'd4096;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_GRAY     = 3'd1,
		OP_BRIGHT   = 3'd2,
		OP_CONTRAST = 3'd3,
		OP_INVERT   = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] value;
	} stage_cfg_t;

	typedef struct packed {
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic [7:0] alpha_in;
		logic       last_in_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic [7:0] alpha_out;
		logic       last_out;
	} out_item_t;

	// Pixel as it travels between filter stages
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last;
	} pix_t;

endpackage

`default_nettype wire

/* rtl/pcfc_stage.sv */
// One filter stage: luma, one multiply per channel, bias add and clamp
`default_nettype none

module pcfc_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pcfc_pkg::stage_cfg_t cfg,
	input  wire logic               in_valid,
	input  wire pcfc_pkg::pix_t     in_pix,
	output logic                    out_valid,
	output pcfc_pkg::pix_t          out_pix
);

	// Luma weights over 65536
	localparam logic [23:0] LUMA_R = 24'd19595;
	localparam logic [23:0] LUMA_G = 24'd38470;
	localparam logic [23:0] LUMA_B = 24'd7471;
	// 128 in Q.12, the contrast pivot
	localparam logic [19:0] CONTRAST_BIAS = 20'd524288;

	// Operands of the one multiply each channel gets
	typedef struct packed {
		logic signed [8:0]  x;
		logic signed [16:0] y;
		logic [19:0]        bias;
	} mul_op_t;

	// Every operation is bias + x*y, then floor and clamp.
	// Mixing: p*4096 + (target - p)*a. Skipped stages: bias p*4096 only.
	function automatic mul_op_t pick(pcfc_pkg::op_t op, logic [15:0] v,
			logic [7:0] p, logic [7:0] luma);
		mul_op_t     r;
		logic [12:0] a;
		logic [15:0] f;
		a = (v > pcfc_pkg::ONE_Q12) ? pcfc_pkg::ONE_Q12[12:0] : v[12:0];
		f = (v == 16'd0) ? pcfc_pkg::ONE_Q12 : v;
		r.x    = 9'sd0;
		r.y    = 17'sd0;
		r.bias = {p, 12'd0};
		case (op)
			pcfc_pkg::OP_GRAY: begin
				if (v != 16'd0) begin
					r.x = $signed({1'b0, luma}) - $signed({1'b0, p});
					r.y = $signed({4'd0, a});
				end
			end
			pcfc_pkg::OP_INVERT: begin
				if (v != 16'd0) begin
					r.x = $signed({1'b0, ~p}) - $signed({1'b0, p});
					r.y = $signed({4'd0, a});
				end
			end
			pcfc_pkg::OP_BRIGHT: begin
				r.x    = $signed({1'b0, p});
				r.y    = $signed({1'b0, f});
				r.bias = 20'd0;
			end
			pcfc_pkg::OP_CONTRAST: begin
				r.x    = $signed({1'b0, p}) - 9'sd128;
				r.y    = $signed({1'b0, f});
				r.bias = CONTRAST_BIAS;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Floor of sum / 4096, clamped to 0..255
	function automatic logic [7:0] clamp_q12(logic signed [26:0] s);
		logic [7:0] r;
		if (s[26])
			r = 8'd0;
		else if (|s[25:20])
			r = 8'd255;
		else
			r = s[19:12];
		return r;
	endfunction

	// Stage 1: luma of the incoming pixel
	logic [23:0]    luma_sum;
	logic           valid_s1;
	pcfc_pkg::pix_t pix_s1;
	logic [7:0]     luma_s1;

	assign luma_sum = LUMA_R * {16'd0, in_pix.red} + LUMA_G * {16'd0, in_pix.green}
		+ LUMA_B * {16'd0, in_pix.blue};

	// Stage 2: per-channel operand selection and multiply
	logic [7:0]         chan_s1 [3];
	mul_op_t            mop     [3];
	logic signed [25:0] prod    [3];
	logic signed [25:0] prod_s2 [3];
	logic [19:0]        bias_s2 [3];
	logic               valid_s2;
	logic [7:0]         alpha_s2;
	logic               last_s2;

	assign chan_s1[0] = pix_s1.blue;
	assign chan_s1[1] = pix_s1.green;
	assign chan_s1[2] = pix_s1.red;

	for (genvar k = 0; k < 3; k++) begin : g_mul
		assign mop[k]  = pick(cfg.op, cfg.value, chan_s1[k], luma_s1);
		assign prod[k] = mop[k].x * mop[k].y;
	end

	// Stage 3: bias add, floor and clamp
	logic signed [26:0] sum  [3];
	logic [7:0]         res  [3];
	logic               valid_s3;
	pcfc_pkg::pix_t     pix_s3;

	for (genvar k = 0; k < 3; k++) begin : g_sum
		assign sum[k] = {prod_s2[k][25], prod_s2[k]} + $signed({7'd0, bias_s2[k]});
		assign res[k] = clamp_q12(sum[k]);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		pix_s1  <= in_pix;
		luma_s1 <= luma_sum[23:16];
		for (int k = 0; k < 3; k++) begin
			prod_s2[k] <= prod[k];
			bias_s2[k] <= mop[k].bias;
		end
		alpha_s2     <= pix_s1.alpha;
		last_s2      <= pix_s1.last;
		pix_s3.blue  <= res[0];
		pix_s3.green <= res[1];
		pix_s3.red   <= res[2];
		pix_s3.alpha <= alpha_s2;
		pix_s3.last  <= last_s2;
	end

	assign out_valid = valid_s3;
	assign out_pix   = pix_s3;

endmodule

`default_nettype wire

/* rtl/pixel_color_filter_chain.sv */
// Top level: configuration registers and the chain of filter stages
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  pixel in  | start, busy               | pixel (in_item_t)
//  result    | done (one-cycle strobe)   | result (out_item_t)
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One pixel is taken every cycle; busy never rises. Each result passes
// through every filter stage, which registers in turn the luma, the channel
// multiplies, and the bias add and clamp.
// The pipeline never stalls, since results cannot be held off.
// Reset clears the valid bits and sets every stage to none with value 1.0.
// cfg_ready is always high; writes to indexes above 7 are dropped.
`default_nettype none

`include "pixel_color_filter_chain_defines.svh"

module pixel_color_filter_chain (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire pcfc_pkg::in_item_t              pixel,
	output logic                                 done,
	output pcfc_pkg::out_item_t                  result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pcfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pcfc_pkg::CFG_DATA_W-1:0] cfg_data
);

	pcfc_pkg::op_t    op_q    [pcfc_pkg::REG_STAGES];
	logic [15:0]      value_q [pcfc_pkg::REG_STAGES];
	logic             cfg_wr;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index < pcfc_pkg::NUM_CFG_REGS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < pcfc_pkg::REG_STAGES; s++) begin
				op_q[s]    <= pcfc_pkg::OP_NONE;
				value_q[s] <= pcfc_pkg::ONE_Q12;
			end
		end else begin
			for (int s = 0; s < pcfc_pkg::REG_STAGES; s++) begin
				if (cfg_wr && cfg_index[pcfc_pkg::CFG_STAGE_W:1]
						== pcfc_pkg::CFG_STAGE_W'(s)) begin
					if (cfg_index[0] == pcfc_pkg::CFG_SEL_OP)
						op_q[s] <= pcfc_pkg::op_t'(cfg_data[2:0]);
					else if (cfg_index[0] == pcfc_pkg::CFG_SEL_VALUE)
						value_q[s] <= cfg_data[15:0];
				end
			end
		end
	end

	// Filter chain
	logic           chain_valid [pcfc_pkg::NUM_STAGES+1];
	pcfc_pkg::pix_t chain_pix   [pcfc_pkg::NUM_STAGES+1];

	assign chain_valid[0]     = start && !busy;
	assign chain_pix[0].blue  = pixel.blue_in;
	assign chain_pix[0].green = pixel.green_in;
	assign chain_pix[0].red   = pixel.red_in;
	assign chain_pix[0].alpha = pixel.alpha_in;
	assign chain_pix[0].last  = pixel.last_in_frame;

	for (genvar i = 0; i < pcfc_pkg::NUM_STAGES; i++) begin : g_stage
		pcfc_pkg::stage_cfg_t scfg;
		if (i < pcfc_pkg::REG_STAGES) begin : g_reg
			assign scfg.op    = op_q[i];
			assign scfg.value = value_q[i];
		end else begin : g_pass
			assign scfg.op    = pcfc_pkg::OP_NONE;
			assign scfg.value = pcfc_pkg::ONE_Q12;
		end
		pcfc_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (scfg),
			.in_valid  (chain_valid[i]),
			.in_pix    (chain_pix[i]),
			.out_valid (chain_valid[i+1]),
			.out_pix   (chain_pix[i+1])
		);
	end

	// Result strobe and payload
	assign done             = chain_valid[pcfc_pkg::NUM_STAGES];
	assign result.blue_out  = chain_pix[pcfc_pkg::NUM_STAGES].blue;
	assign result.green_out = chain_pix[pcfc_pkg::NUM_STAGES].green;
	assign result.red_out   = chain_pix[pcfc_pkg::NUM_STAGES].red;
	assign result.alpha_out = chain_pix[pcfc_pkg::NUM_STAGES].alpha;
	assign result.last_out  = chain_pix[pcfc_pkg::NUM_STAGES].last;

	// Every result comes from an item taken at the chain input
	`PCFC_ASSERT_NOW(a_done_has_item, clk, arst_n, done, $past(chain_valid[0], pcfc_pkg::LATENCY))
	// Alpha and the frame-end mark ride with their pixel
	`PCFC_ASSERT_NOW(a_alpha_kept, clk, arst_n, done, result.alpha_out == $past(pixel.alpha_in, pcfc_pkg::LATENCY))
	`PCFC_ASSERT_NOW(a_last_kept, clk, arst_n, done, result.last_out == $past(pixel.last_in_frame, pcfc_pkg::LATENCY))
	// An item at the chain input is in the first stage's first register on the next cycle
	`PCFC_ASSERT_NEXT(a_first_stage_moves, clk, arst_n, chain_valid[0], g_stage[0].u_stage.valid_s1)

endmodule

`default_nettype wire

/* tb/pixel_filter_checker.sv */
// Checker for the colour filter chain: predicts each filtered pixel and compares results
`default_nettype none

module pixel_filter_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            busy,
	input  wire pcfc_pkg::in_item_t              pixel,
	input  wire logic                            done,
	input  wire pcfc_pkg::out_item_t             result,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [pcfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pcfc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                          fail_count,
	output int unsigned                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_LIMIT  = 10;
	// Far more than the pipeline can hold at once
	localparam int unsigned PENDING_DEPTH = 64;
	localparam int unsigned PENDING_W     = $clog2(PENDING_DEPTH);

	// Shadow copy of the stage registers
	logic [2:0]  stage_op_copy    [pcfc_pkg::REG_STAGES];
	logic [15:0] stage_value_copy [pcfc_pkg::REG_STAGES];

	// Filtered pixels still owed by the block, kept in a ring, oldest at rd_ptr
	pcfc_pkg::out_item_t  expected_pixels [PENDING_DEPTH];
	logic [PENDING_W-1:0] wr_ptr;
	logic [PENDING_W-1:0] rd_ptr;

	// Run one pixel through the configured stages
	function automatic pcfc_pkg::out_item_t filter_pixel(input pcfc_pkg::in_item_t px);
		int unsigned         ch [3];
		int unsigned         amt;
		int unsigned         fac;
		int unsigned         luma;
		int unsigned         v;
		longint              t;
		pcfc_pkg::out_item_t r;
		ch[0] = px.blue_in;
		ch[1] = px.green_in;
		ch[2] = px.red_in;
		for (int s = 0; s < pcfc_pkg::NUM_STAGES && s < pcfc_pkg::REG_STAGES; s++) begin
			v = stage_value_copy[s];
			amt = (v > pcfc_pkg::ONE_Q12) ? pcfc_pkg::ONE_Q12 : v;
			fac = (v == 0) ? pcfc_pkg::ONE_Q12 : v;
			case (stage_op_copy[s])
				pcfc_pkg::OP_GRAY: begin
					// zero amount leaves the pixel alone
					if (v != 0) begin
						luma = (19595 * ch[2] + 38470 * ch[1] + 7471 * ch[0]) >> 16;
						for (int k = 0; k < 3; k++)
							ch[k] = (ch[k] * (pcfc_pkg::ONE_Q12 - amt) + luma * amt) >> 12;
					end
				end
				pcfc_pkg::OP_BRIGHT: begin
					for (int k = 0; k < 3; k++) begin
						ch[k] = (ch[k] * fac) >> 12;
						if (ch[k] > 255)
							ch[k] = 255;
					end
				end
				pcfc_pkg::OP_CONTRAST: begin
					for (int k = 0; k < 3; k++) begin
						t = (longint'(ch[k]) - 128) * longint'(fac) + 128 * 4096;
						if (t < 0)
							ch[k] = 0;
						else if ((t >> 12) > 255)
							ch[k] = 255;
						else
							ch[k] = int'(t >> 12);
					end
				end
				pcfc_pkg::OP_INVERT: begin
					if (v != 0) begin
						for (int k = 0; k < 3; k++)
							ch[k] = (ch[k] * (pcfc_pkg::ONE_Q12 - amt)
								+ (255 - ch[k]) * amt) >> 12;
					end
				end
				default: begin
					// none, and the spare codes
				end
			endcase
		end
		r.blue_out  = ch[0][7:0];
		r.green_out = ch[1][7:0];
		r.red_out   = ch[2][7:0];
		r.alpha_out = px.alpha_in;
		r.last_out  = px.last_in_frame;
		return r;
	endfunction

	// Track register writes, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		pcfc_pkg::out_item_t want;
		logic                bad;
		logic                took;
		logic                gave;
		if (!arst_n) begin
			for (int s = 0; s < pcfc_pkg::REG_STAGES; s++) begin
				stage_op_copy[s]    <= pcfc_pkg::OP_NONE;
				stage_value_copy[s] <= pcfc_pkg::ONE_Q12;
			end
			wr_ptr      <= '0;
			rd_ptr      <= '0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			took = start && !busy;
			gave = 1'b0;

			// register write; indexes past the last pair are dropped
			if (cfg_valid && cfg_ready && cfg_index < pcfc_pkg::NUM_CFG_REGS) begin
				if (cfg_index[0] == pcfc_pkg::CFG_SEL_OP)
					stage_op_copy[cfg_index[pcfc_pkg::CFG_STAGE_W:1]] <= cfg_data[2:0];
				else
					stage_value_copy[cfg_index[pcfc_pkg::CFG_STAGE_W:1]] <= cfg_data;
			end

			if (took) begin
				expected_pixels[wr_ptr] <= filter_pixel(pixel);
				wr_ptr                  <= wr_ptr + 1'b1;
			end

			if (done) begin
				if (outstanding == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: unexpected result b=%0d g=%0d r=%0d a=%0d last=%0b",
							$time, result.blue_out, result.green_out, result.red_out,
							result.alpha_out, result.last_out);
					fail_count <= fail_count + 1;
				end else begin
					want   = expected_pixels[rd_ptr];
					gave   = 1'b1;
					rd_ptr <= rd_ptr + 1'b1;
					bad = (result.blue_out  !== want.blue_out)  ||
					      (result.green_out !== want.green_out) ||
					      (result.red_out   !== want.red_out)   ||
					      (result.alpha_out !== want.alpha_out) ||
					      (result.last_out  !== want.last_out);
					if (bad) begin
						if (fail_count < REPORT_LIMIT)
							$display({"%0t: mismatch, expected b=%0d g=%0d r=%0d a=%0d last=%0b,",
								" got b=%0d g=%0d r=%0d a=%0d last=%0b"}, $time,
								want.blue_out, want.green_out, want.red_out,
								want.alpha_out, want.last_out,
								result.blue_out, result.green_out, result.red_out,
								result.alpha_out, result.last_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			outstanding <= outstanding + (took ? 1 : 0) - (gave ? 1 : 0);
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench top: stimulus, configuration phases, watchdog and verdict for the filter chain
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS   = 1200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
	localparam int unsigned IDX_TOP        = (1 << pcfc_pkg::CFG_IDX_W) - 1;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            start     = 1'b0;
	pcfc_pkg::in_item_t              pixel     = '0;
	logic                            cfg_valid = 1'b0;
	logic [pcfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pcfc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            busy;
	logic                            done;
	pcfc_pkg::out_item_t             result;
	logic                            cfg_ready;
	int unsigned                     fail_count;
	int unsigned                     outstanding;
	int unsigned                     idle_cycles = 0;
	int unsigned                     random_sent = 0;
	logic                            burst = 1'b0;

	// Stage settings for the next phase
	logic [2:0]  plan_op    [pcfc_pkg::REG_STAGES];
	logic [15:0] plan_value [pcfc_pkg::REG_STAGES];

	always #1 clk = ~clk;

	pixel_color_filter_chain uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pixel_filter_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel       (pixel),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Watchdog: give up after a long stretch with nothing moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Mostly short gaps, a few long ones, none in burst phases
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic pcfc_pkg::in_item_t make_pixel(input logic [7:0] b,
		input logic [7:0] g, input logic [7:0] r, input logic [7:0] a, input logic l);
		pcfc_pkg::in_item_t px;
		px.blue_in       = b;
		px.green_in      = g;
		px.red_in        = r;
		px.alpha_in      = a;
		px.last_in_frame = l;
		return px;
	endfunction

	// Channel value: mostly random, sometimes an edge value
	function automatic logic [7:0] pick_channel();
		logic [7:0] edges [6] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254};
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, 255));
		return edges[$urandom_range(0, 5)];
	endfunction

	// Stage value: zero, one, tiny, just above one, full scale or anything
	function automatic logic [15:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'd0;
		if (r < 30)
			return pcfc_pkg::ONE_Q12;
		if (r < 40)
			return 16'hFFFF;
		if (r < 50)
			return 16'($urandom_range(1, 16));
		if (r < 60)
			return 16'($urandom_range(pcfc_pkg::ONE_Q12 + 1, 2 * pcfc_pkg::ONE_Q12));
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [2:0] pick_op();
		if ($urandom_range(0, 99) < 85)
			return 3'($urandom_range(pcfc_pkg::OP_NONE, pcfc_pkg::OP_INVERT));
		return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
	endfunction

	task automatic send_pixel(input pcfc_pkg::in_item_t px);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [pcfc_pkg::CFG_IDX_W-1:0] idx,
		input logic [pcfc_pkg::CFG_DATA_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every stage register in a rotated order; op writes carry junk upper bits
	task automatic load_plan(input logic stray);
		int unsigned rot;
		int unsigned idx;
		rot = $urandom_range(0, pcfc_pkg::NUM_CFG_REGS - 1);
		if (stray)
			write_reg(pcfc_pkg::CFG_IDX_W'($urandom_range(pcfc_pkg::NUM_CFG_REGS, IDX_TOP)),
				pcfc_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
		for (int n = 0; n < pcfc_pkg::NUM_CFG_REGS; n++) begin
			idx = (n + rot) % pcfc_pkg::NUM_CFG_REGS;
			if (idx[0] == pcfc_pkg::CFG_SEL_OP)
				write_reg(pcfc_pkg::CFG_IDX_W'(idx),
					{13'($urandom_range(0, 16'h1FFF)),
					plan_op[idx[pcfc_pkg::CFG_STAGE_W:1]]});
			else
				write_reg(pcfc_pkg::CFG_IDX_W'(idx),
					plan_value[idx[pcfc_pkg::CFG_STAGE_W:1]]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Let every owed result come out, then let the pipeline empty
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (pcfc_pkg::LATENCY) @(posedge clk);
	endtask

	task automatic set_plan(input logic [2:0] o0, input logic [15:0] v0,
		input logic [2:0] o1, input logic [15:0] v1,
		input logic [2:0] o2, input logic [15:0] v2,
		input logic [2:0] o3, input logic [15:0] v3);
		plan_op[0] = o0; plan_value[0] = v0;
		plan_op[1] = o1; plan_value[1] = v1;
		plan_op[2] = o2; plan_value[2] = v2;
		plan_op[3] = o3; plan_value[3] = v3;
	endtask

	initial begin
		int unsigned phase_len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every stage passes the pixel through
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1));
		drain();

		// Full grayscale alone
		set_plan(pcfc_pkg::OP_GRAY, pcfc_pkg::ONE_Q12, pcfc_pkg::OP_NONE, pcfc_pkg::ONE_Q12,
			pcfc_pkg::OP_NONE, pcfc_pkg::ONE_Q12, pcfc_pkg::OP_NONE, pcfc_pkg::ONE_Q12);
		load_plan(1'b0);
		send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd17, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd34, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd51, 1'b1));
		drain();

		// Zero amounts and zero factors: all four stages leave the pixel as it is
		set_plan(pcfc_pkg::OP_GRAY, 16'd0, pcfc_pkg::OP_INVERT, 16'd0,
			pcfc_pkg::OP_BRIGHT, 16'd0, pcfc_pkg::OP_CONTRAST, 16'd0);
		load_plan(1'b0);
		send_pixel(make_pixel(8'd12, 8'd200, 8'd99, 8'd1, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd128, 8'd0, 8'd254, 1'b1));
		drain();

		// Full-scale values: amounts saturate, brightness and contrast clip
		set_plan(pcfc_pkg::OP_BRIGHT, 16'hFFFF, pcfc_pkg::OP_CONTRAST, 16'hFFFF,
			pcfc_pkg::OP_GRAY, 16'hFFFF, pcfc_pkg::OP_INVERT, 16'hFFFF);
		load_plan(1'b0);
		send_pixel(make_pixel(8'd1, 8'd127, 8'd128, 8'd9, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'd77, 1'b1));
		drain();

		// Spare op codes act as none; writes past the last register are dropped
		set_plan(OP_SPARE_FIRST, 16'd1234, OP_SPARE_FIRST + 3'd1, 16'hFFFF,
			OP_SPARE_LAST, 16'd0, pcfc_pkg::OP_INVERT, 16'd2048);
		write_reg(pcfc_pkg::CFG_IDX_W'(IDX_TOP), 16'hFFFF);
		write_reg(pcfc_pkg::CFG_IDX_W'(pcfc_pkg::NUM_CFG_REGS), 16'h0000);
		load_plan(1'b1);
		send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd40, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd200, 1'b1));
		drain();

		// Tiny factors: contrast pulls toward mid-grey, brightness toward black
		set_plan(pcfc_pkg::OP_CONTRAST, 16'd1, pcfc_pkg::OP_NONE, pcfc_pkg::ONE_Q12,
			pcfc_pkg::OP_BRIGHT, 16'd1, pcfc_pkg::OP_NONE, pcfc_pkg::ONE_Q12);
		load_plan(1'b0);
		send_pixel(make_pixel(8'd0, 8'd255, 8'd127, 8'd3, 1'b0));
		send_pixel(make_pixel(8'd128, 8'd1, 8'd254, 8'd4, 1'b1));
		drain();

		// Random phases: new settings each time, then a run of pixels
		while (random_sent < RANDOM_ITEMS) begin
			for (int s = 0; s < pcfc_pkg::REG_STAGES; s++) begin
				plan_op[s]    = pick_op();
				plan_value[s] = pick_value();
			end
			burst = ($urandom_range(0, 3) == 0);
			load_plan($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(10, 60);
			for (int n = 0; n < phase_len; n++) begin
				send_pixel(make_pixel(pick_channel(), pick_channel(), pick_channel(),
					8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0)));
				random_sent++;
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
